// File: rtl/bmp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmp_pkg
// Shared constants, command codes and control bundles of the bias matrix
// projection unit.
// ---------------------------------------------------------------------------
package bmp_pkg;

   localparam int DATA_W  = 16;
   localparam int IDX_W   = 6;
   localparam int TDATA_W = 32;

   // sized for the largest feature count: 64 products of 32 bits plus bias
   localparam int ACC_W = 41;

   localparam int TOKENS_DEF    = 16;
   localparam int IN_DIM_DEF    = 64;
   localparam int OUT_DIM_DEF   = 64;
   localparam int FRAC_BITS_DEF = 8;

   localparam logic [1:0] CMD_LOAD_TOKEN  = 2'd0;
   localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd1;
   localparam logic [1:0] CMD_LOAD_BIAS   = 2'd2;
   localparam logic [1:0] CMD_READ        = 2'd3;

   typedef struct packed {
      logic tok_we;
      logic wgt_we;
      logic bias_we;
   } mem_wr_type;

   typedef struct packed {
      logic bias_issue;
      logic mul_issue;
      logic mul_last;
   } mac_ctl_type;

endpackage
`default_nettype wire

// File: rtl/bmp_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmp_mem
// Token, weight and bias stores, one write and one registered read each.
// ---------------------------------------------------------------------------
module bmp_mem #(
   parameter int TOKENS  = bmp_pkg::TOKENS_DEF,
   parameter int IN_DIM  = bmp_pkg::IN_DIM_DEF,
   parameter int OUT_DIM = bmp_pkg::OUT_DIM_DEF,
   localparam int TA = (TOKENS * IN_DIM > 1) ? $clog2(TOKENS * IN_DIM) : 1,
   localparam int WA = (IN_DIM * OUT_DIM > 1) ? $clog2(IN_DIM * OUT_DIM) : 1,
   localparam int BA = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1
) (
   input  wire                              clock,
   input  wire  bmp_pkg::mem_wr_type        wr,
   input  wire  [TA-1:0]                    tok_wr_addr,
   input  wire  [WA-1:0]                    wgt_wr_addr,
   input  wire  [BA-1:0]                    bias_wr_addr,
   input  wire  [bmp_pkg::DATA_W-1:0]       wr_data,
   input  wire  [TA-1:0]                    tok_rd_addr,
   input  wire  [WA-1:0]                    wgt_rd_addr,
   input  wire  [BA-1:0]                    bias_rd_addr,
   output logic [bmp_pkg::DATA_W-1:0]       tok_rd_data,
   output logic [bmp_pkg::DATA_W-1:0]       wgt_rd_data,
   output logic [bmp_pkg::DATA_W-1:0]       bias_rd_data
);
   import bmp_pkg::*;

   logic [DATA_W-1:0] tok_mem  [TOKENS*IN_DIM];
   logic [DATA_W-1:0] wgt_mem  [IN_DIM*OUT_DIM];
   logic [DATA_W-1:0] bias_mem [OUT_DIM];

   always_ff @(posedge clock) begin
      if (wr.tok_we) begin
         tok_mem[tok_wr_addr] <= wr_data;
      end
      tok_rd_data <= tok_mem[tok_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.wgt_we) begin
         wgt_mem[wgt_wr_addr] <= wr_data;
      end
      wgt_rd_data <= wgt_mem[wgt_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.bias_we) begin
         bias_mem[bias_wr_addr] <= wr_data;
      end
      bias_rd_data <= bias_mem[bias_rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/bmp_mac.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmp_mac
// Multiply-accumulate datapath: registered product, exact wide accumulator
// preloaded with the aligned bias.
// ---------------------------------------------------------------------------
module bmp_mac #(
   parameter int FRAC_BITS = bmp_pkg::FRAC_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  bmp_pkg::mac_ctl_type       ctl,
   input  wire  [bmp_pkg::DATA_W-1:0]       bias_data,
   input  wire  [bmp_pkg::DATA_W-1:0]       tok_data,
   input  wire  [bmp_pkg::DATA_W-1:0]       wgt_data,
   output logic [bmp_pkg::ACC_W-1:0]        acc,
   output logic                             done
);
   import bmp_pkg::*;

   logic                     bias_vld_ff;
   logic                     rd_vld_ff;
   logic                     rd_last_ff;
   logic                     prod_vld_ff;
   logic                     prod_last_ff;
   logic                     done_ff;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  bias_ext;

   // memory data arrives in the cycle after the issue
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_vld_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         bias_vld_ff  <= ctl.bias_issue;
         rd_vld_ff    <= ctl.mul_issue;
         rd_last_ff   <= ctl.mul_issue & ctl.mul_last;
         prod_vld_ff  <= rd_vld_ff;
         prod_last_ff <= rd_last_ff;
         done_ff      <= prod_vld_ff & prod_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= $signed(tok_data) * $signed(wgt_data);
      end
   end

   assign bias_ext = ACC_W'($signed(bias_data)) <<< FRAC_BITS;

   always_comb begin
      acc_in = acc_ff;
      if (bias_vld_ff) begin
         acc_in = bias_ext;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// File: rtl/bias_matrix_projection_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bias_matrix_projection_unit
// Fixed-point matrix projection with bias over on-chip token, weight and
// bias stores.
// ---------------------------------------------------------------------------
// Load requests (token, weight or bias element) write one store entry and
// leave the block ready for the next request; loads with indices outside
// the sizes are dropped. A read request for token t and output o returns
// bias[o] + sum_k token[t][k] * weight[k][o] in Q8.8, floor-shifted by
// FRAC_BITS and wrapped to 16 bits. A read walks the token row and weight
// column through one multiply-accumulate unit fed by the stores' read ports,
// one feature per cycle, through the store read, product and accumulator
// registers; no new request is taken until the result reaches the output
// register. An out-of-range read skips the sum: its result, zero with
// in_range low, goes from the final state to the output register, and the
// next request is taken once it is there. A finished result sits in an
// output register, so loads keep flowing while it waits to be taken; a read
// that finishes while that register is still full holds the block until
// the result is taken. Store entries must be written before they are read.
// ---------------------------------------------------------------------------
module bias_matrix_projection_unit #(
   parameter int TOKENS    = bmp_pkg::TOKENS_DEF,
   parameter int IN_DIM    = bmp_pkg::IN_DIM_DEF,
   parameter int OUT_DIM   = bmp_pkg::OUT_DIM_DEF,
   parameter int FRAC_BITS = bmp_pkg::FRAC_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // row_index[5:0], col_index[11:6], load_value[27:12], zero[31:28]
   input  wire  [bmp_pkg::TDATA_W-1:0]      req_tdata,
   // cmd[1:0]
   input  wire  [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // token_index[5:0], output_index[11:6], result_value[27:12], zero[31:28]
   output logic [bmp_pkg::TDATA_W-1:0]      rsp_tdata,
   // in_range[0]
   output logic [0:0]                       rsp_tuser
);
   import bmp_pkg::*;

   localparam int TA = (TOKENS * IN_DIM > 1) ? $clog2(TOKENS * IN_DIM) : 1;
   localparam int WA = (IN_DIM * OUT_DIM > 1) ? $clog2(IN_DIM * OUT_DIM) : 1;
   localparam int BA = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
   localparam int KW = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [IDX_W-1:0]  req_row;
   logic [IDX_W-1:0]  req_col;
   logic [DATA_W-1:0] req_value;
   logic              req_fire;
   logic              read_ok;

   logic [1:0]        state_ff, state_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [TA-1:0]     tok_ptr_ff, tok_ptr_in;
   logic [WA-1:0]     wgt_ptr_ff, wgt_ptr_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic              range_ff, range_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_token_ff, rsp_token_in;
   logic [IDX_W-1:0]  rsp_output_ff, rsp_output_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_range_ff, rsp_range_in;

   mem_wr_type        wr;
   mac_ctl_type       mac_ctl;
   logic [TA-1:0]     tok_wr_addr;
   logic [WA-1:0]     wgt_wr_addr;
   logic [BA-1:0]     bias_addr;
   logic [DATA_W-1:0] tok_rd_data;
   logic [DATA_W-1:0] wgt_rd_data;
   logic [DATA_W-1:0] bias_rd_data;
   logic [ACC_W-1:0]  acc;
   logic              mac_done;
   logic              k_last;
   logic              out_free;

   assign req_row   = req_tdata[IDX_W-1:0];
   assign req_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value = req_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign read_ok    = (int'(req_row) < TOKENS) && (int'(req_col) < OUT_DIM);
   assign k_last     = (k_ff == KW'(IN_DIM - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign tok_wr_addr = TA'(int'(req_row) * IN_DIM + int'(req_col));
   assign wgt_wr_addr = WA'(int'(req_row) * OUT_DIM + int'(req_col));
   assign bias_addr   = BA'(req_col);

   always_comb begin
      wr = '0;
      if (req_fire) begin
         unique case (req_tuser)
            CMD_LOAD_TOKEN: begin
               wr.tok_we = (int'(req_row) < TOKENS) && (int'(req_col) < IN_DIM);
            end
            CMD_LOAD_WEIGHT: begin
               wr.wgt_we = (int'(req_row) < IN_DIM) && (int'(req_col) < OUT_DIM);
            end
            CMD_LOAD_BIAS: begin
               wr.bias_we = (int'(req_col) < OUT_DIM);
            end
            CMD_READ: begin
               wr = '0;
            end
            default: begin
               wr = '0;
            end
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      tok_ptr_in = tok_ptr_ff;
      wgt_ptr_in = wgt_ptr_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      range_in   = range_ff;
      mac_ctl    = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_token_in  = rsp_token_ff;
      rsp_output_in = rsp_output_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_range_in  = rsp_range_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == CMD_READ) begin
               row_in     = req_row;
               col_in     = req_col;
               range_in   = read_ok;
               k_in       = '0;
               tok_ptr_in = TA'(int'(req_row) * IN_DIM);
               wgt_ptr_in = WA'(req_col);
               // bias word passes the store read register, then loads the accumulator
               mac_ctl.bias_issue = read_ok;
               state_in   = read_ok ? ST_RUN : ST_FIN;
            end
         end
         ST_RUN: begin
            mac_ctl.mul_issue = 1'b1;
            mac_ctl.mul_last  = k_last;
            k_in       = k_ff + KW'(1);
            tok_ptr_in = tok_ptr_ff + TA'(1);
            wgt_ptr_in = wgt_ptr_ff + WA'(OUT_DIM);
            if (k_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_token_in  = row_ff;
               rsp_output_in = col_ff;
               rsp_range_in  = range_ff;
               // floor shift and wrap: take 16 bits above the fraction
               rsp_value_in  = range_ff ? acc[FRAC_BITS +: DATA_W] : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      tok_ptr_ff    <= tok_ptr_in;
      wgt_ptr_ff    <= wgt_ptr_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      range_ff      <= range_in;
      rsp_token_ff  <= rsp_token_in;
      rsp_output_ff <= rsp_output_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_range_ff  <= rsp_range_in;
   end

   bmp_mem #(
      .TOKENS  (TOKENS),
      .IN_DIM  (IN_DIM),
      .OUT_DIM (OUT_DIM)
   ) u_mem (
      .clock        (clock),
      .wr           (wr),
      .tok_wr_addr  (tok_wr_addr),
      .wgt_wr_addr  (wgt_wr_addr),
      .bias_wr_addr (bias_addr),
      .wr_data      (req_value),
      .tok_rd_addr  (tok_ptr_ff),
      .wgt_rd_addr  (wgt_ptr_ff),
      .bias_rd_addr (bias_addr),
      .tok_rd_data  (tok_rd_data),
      .wgt_rd_data  (wgt_rd_data),
      .bias_rd_data (bias_rd_data)
   );

   bmp_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mac_ctl),
      .bias_data (bias_rd_data),
      .tok_data  (tok_rd_data),
      .wgt_data  (wgt_rd_data),
      .acc       (acc),
      .done      (mac_done)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(TDATA_W - 2*IDX_W - DATA_W)'(0), rsp_value_ff,
                        rsp_output_ff, rsp_token_ff};
   assign rsp_tuser  = rsp_range_ff;

   // accumulation only finishes while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_WAIT))
      else $error("accumulator finished outside of wait state");

   // result stage is reached from wait only once the sum is complete
   a_fin_after_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN) && ($past(state_ff) == ST_WAIT)) |-> $past(mac_done))
      else $error("result taken before accumulation finished");

   // out-of-range reads report a zero value
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_range_ff) |-> (rsp_value_ff == '0))
      else $error("out-of-range read returned nonzero value");

   // feature counter stays inside the row while issuing
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (int'(k_ff) < IN_DIM))
      else $error("feature counter out of range");

endmodule
`default_nettype wire
